/* hdl/gclp_pkg.sv */
// ----------------------------------------------------------------------------
// G-code line parser package
// Shared codes, types and helpers for the G-code line parser core.
// ----------------------------------------------------------------------------
package gclp_pkg;

    // Default configuration
    localparam int FRACTION_DIGITS_DEF = 3;
    localparam int VALUE_WIDTH_DEF     = 32;

    // Line status codes; ST_OK also means "no error yet" inside the line
    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_EMPTY        = 3'd1,
        ST_BAD_NUMBER   = 3'd2,
        ST_DUPLICATE    = 3'd3,
        ST_UNSUPPORTED  = 3'd4,
        ST_NONINTEGER   = 3'd5,
        ST_OPEN_COMMENT = 3'd6
    } status_t;

    // Word letters, in present_mask bit order
    typedef enum logic [2:0] {
        L_G = 3'd0,
        L_M = 3'd1,
        L_X = 3'd2,
        L_Y = 3'd3,
        L_F = 3'd4,
        L_S = 3'd5
    } letter_t;

    // Characters with a meaning of their own
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SEMI  = 8'h3B;

    // G/M integer limits; the integer part saturates just above both
    localparam logic [15:0] CODE_POS_MAX = 16'd32767;
    localparam logic [15:0] CODE_NEG_MAX = 16'd32768;
    localparam logic [15:0] CODE_SAT     = 16'd32769;

    // Flags and integer part of the number being read
    typedef struct packed {
        logic        negative;
        logic        digit_seen;
        logic        dot_seen;
        logic        overflow;
        logic        frac_nz;
        logic [15:0] int_code;
    } num_flags_t;

    // Outcome of closing a number
    typedef struct packed {
        status_t    err;
        logic [5:0] word_bit;
    } fin_t;

    // Width of the retained fraction digit counter
    function automatic int frac_cnt_width(input int fd);
        int w;
        w = 1;
        while ((1 << w) < (fd + 1)) begin
            w = w + 1;
        end
        return w;
    endfunction

endpackage

/* hdl/gclp_if.sv */
// ----------------------------------------------------------------------------
// G-code line parser channels
// Character input channel and line result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface gclp_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;

    modport source (output valid, output char_byte, input ready);
    modport sink   (input valid, input char_byte, output ready);
endinterface

interface gclp_result_if;
    logic               valid;
    logic               ready;
    logic        [2:0]  status;
    logic        [5:0]  present_mask;
    logic signed [15:0] g_code;
    logic signed [15:0] m_code;
    logic signed [31:0] x_value;
    logic signed [31:0] y_value;
    logic signed [31:0] feed_value;
    logic signed [31:0] s_value;

    modport source (output valid, output status, output present_mask, output g_code,
                    output m_code, output x_value, output y_value, output feed_value,
                    output s_value, input ready);
    modport sink   (input valid, input status, input present_mask, input g_code,
                    input m_code, input x_value, input y_value, input feed_value,
                    input s_value, output ready);
endinterface

/* hdl/gclp_finish.sv */
// ----------------------------------------------------------------------------
// G-code number close
// Checks a finished number against range, integer and duplicate rules and
// forms the fixed-point value or the G/M code to store.
// ----------------------------------------------------------------------------
module gclp_finish #(
    parameter int FRACTION_DIGITS = gclp_pkg::FRACTION_DIGITS_DEF,
    parameter int VALUE_WIDTH     = gclp_pkg::VALUE_WIDTH_DEF
) (
    input  logic [VALUE_WIDTH-1:0]                            accum,
    input  logic [gclp_pkg::frac_cnt_width(FRACTION_DIGITS)-1:0] frac_cnt,
    input  gclp_pkg::num_flags_t                              flags,
    input  gclp_pkg::letter_t                                 letter,
    input  logic [5:0]                                        seen_mask,
    output gclp_pkg::fin_t                                    fin,
    output logic [15:0]                                       code_value,
    output logic [((VALUE_WIDTH < 32) ? VALUE_WIDTH : 32)-1:0] word_value
);

    localparam int OW = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;

    // Magnitude limit 2^(VALUE_WIDTH-1) and its quotients by powers of ten
    localparam logic [64:0] LIM = 65'd1 << (VALUE_WIDTH - 1);
    localparam logic [64:0] PAD_LIM [8] = '{
        LIM, LIM / 10, LIM / 100, LIM / 1000, LIM / 10000,
        LIM / 100000, LIM / 1000000, LIM / 10000000
    };
    // Low bits of the padding scale factors
    localparam logic [OW-1:0] POW_LO [8] = '{
        OW'(1), OW'(10), OW'(100), OW'(1000), OW'(10000),
        OW'(100000), OW'(1000000), OW'(10000000)
    };

    logic [2:0]    pad_cnt;
    logic          pad_ovf;
    logic          at_lim;
    logic          bad;
    logic          is_code;
    logic          dup;
    logic [5:0]    word_bit;
    logic [15:0]   code_max;
    logic [OW-1:0] scaled;

    // Pad missing fraction digits with zeros: overflow iff accum * 10^k > LIM
    assign pad_cnt = 3'(FRACTION_DIGITS) - 3'(frac_cnt);
    assign pad_ovf = 65'(accum) > PAD_LIM[pad_cnt];
    // Only an unpadded value can equal the power-of-two limit
    assign at_lim  = (pad_cnt == 3'd0) && (65'(accum) == LIM) && !flags.negative;
    assign bad     = !flags.digit_seen || flags.overflow || pad_ovf || at_lim;

    assign is_code  = (letter == gclp_pkg::L_G) || (letter == gclp_pkg::L_M);
    assign word_bit = 6'(1) << letter;
    assign dup      = |(seen_mask & word_bit);
    assign code_max = flags.negative ? gclp_pkg::CODE_NEG_MAX : gclp_pkg::CODE_POS_MAX;

    // Pick the first failing check
    always_comb
    begin
        fin.word_bit = word_bit;
        if (bad)
        begin
            fin.err = gclp_pkg::ST_BAD_NUMBER;
        end
        else if (is_code && flags.frac_nz)
        begin
            fin.err = gclp_pkg::ST_NONINTEGER;
        end
        else if (is_code && (flags.int_code > code_max))
        begin
            fin.err = gclp_pkg::ST_BAD_NUMBER;
        end
        else if (dup)
        begin
            fin.err = gclp_pkg::ST_DUPLICATE;
        end
        else
        begin
            fin.err = gclp_pkg::ST_OK;
        end
    end

    // Form the stored values
    assign code_value = flags.negative ? 16'(16'd0 - flags.int_code) : flags.int_code;
    assign scaled     = OW'(accum[OW-1:0] * POW_LO[pad_cnt]);
    assign word_value = flags.negative ? OW'(OW'(0) - scaled) : scaled;

endmodule

/* hdl/gcode_line_parser_core.sv */
// ----------------------------------------------------------------------------
// G-code line parser core
// Parses one G-code line a character at a time and returns the G, M, X, Y,
// F and S words with a status when the terminating zero byte arrives.
//
//   Channel   Dir  Beat contents
//   chars     in   char_byte: one line character, zero ends the line
//   results   out  status, present_mask, g_code, m_code, x/y/feed/s values
//
// One character beat is taken per cycle, also while a result waits; only a
// zero byte stalls, in the input register, while the previous result is
// still held. A character goes through the input register and the parse
// logic into the line state registers; a taken zero byte leaves a result
// beat in the output register.
// Reset (rst_n low, asynchronous) clears the line state and both valids.
// ----------------------------------------------------------------------------
module gcode_line_parser_core #(
    parameter int FRACTION_DIGITS = gclp_pkg::FRACTION_DIGITS_DEF,
    parameter int VALUE_WIDTH     = gclp_pkg::VALUE_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    gclp_char_if.sink            chars,
    gclp_result_if.source        results
);

    localparam int FCW = gclp_pkg::frac_cnt_width(FRACTION_DIGITS);
    localparam int OW  = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
    localparam int AW  = VALUE_WIDTH + 4;
    localparam logic [AW-1:0] LIM = AW'(1) << (VALUE_WIDTH - 1);

    typedef enum logic [2:0] {
        M_BETWEEN,
        M_AFTER_LETTER,
        M_NUMBER,
        M_COMMENT,
        M_SKIP
    } mode_t;

    // Input register
    logic       chv_reg;
    logic [7:0] ch_reg;

    // Line state
    mode_t                mode_reg,   mode_next;
    gclp_pkg::letter_t    letter_reg, letter_next;
    gclp_pkg::num_flags_t num_reg,    num_next;
    logic [VALUE_WIDTH-1:0] accum_reg, accum_next;
    logic [FCW-1:0]       fc_reg,     fc_next;
    logic [5:0]           mask_reg,   mask_next;
    logic [15:0]          code_reg [2];
    logic [15:0]          code_next [2];
    logic [OW-1:0]        val_reg [4];
    logic [OW-1:0]        val_next [4];
    gclp_pkg::status_t    err_reg,    err_next;

    // Result register
    logic              out_vld_reg;
    gclp_pkg::status_t res_status_reg;
    logic [5:0]        res_mask_reg;
    logic [15:0]       res_code_reg [2];
    logic [31:0]       res_val_reg [4];

    // Parse control
    logic              out_free;
    logic              eol_char;
    logic              advance;
    logic              eol_adv;
    logic              is_space;
    logic              is_digit;
    logic [3:0]        dval;
    logic [7:0]        upper;
    logic              letter_ok;
    gclp_pkg::letter_t letter_dec;
    logic [AW-1:0]     acc10;
    logic [19:0]       ic10;
    logic [1:0]        vidx;
    gclp_pkg::fin_t    fin;
    logic [15:0]       fin_code;
    logic [OW-1:0]     fin_value;
    gclp_pkg::status_t final_status;

    // Handshake
    assign out_free     = !out_vld_reg || results.ready;
    assign eol_char     = (ch_reg == gclp_pkg::CH_NUL);
    assign advance      = chv_reg && (!eol_char || out_free);
    assign eol_adv      = advance && eol_char;
    assign chars.ready  = !chv_reg || advance;

    // Hold the input beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chv_reg <= 1'b0;
        end
        else if (chars.ready)
        begin
            chv_reg <= chars.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (chars.ready)
        begin
            ch_reg <= chars.char_byte;
        end
    end

    // Classify the character
    always_comb
    begin
        case (ch_reg) inside
            [8'd9:8'd13], gclp_pkg::CH_SPACE: is_space = 1'b1;
            default:                          is_space = 1'b0;
        endcase
        is_digit = (ch_reg >= gclp_pkg::CH_ZERO) && (ch_reg <= gclp_pkg::CH_NINE);
        dval     = 4'(ch_reg - gclp_pkg::CH_ZERO);
        upper    = ((ch_reg >= 8'h61) && (ch_reg <= 8'h7A)) ? (ch_reg - 8'h20) : ch_reg;
        letter_ok = 1'b1;
        case (upper)
            8'h47:   letter_dec = gclp_pkg::L_G;
            8'h4D:   letter_dec = gclp_pkg::L_M;
            8'h58:   letter_dec = gclp_pkg::L_X;
            8'h59:   letter_dec = gclp_pkg::L_Y;
            8'h46:   letter_dec = gclp_pkg::L_F;
            8'h53:   letter_dec = gclp_pkg::L_S;
            default:
            begin
                letter_dec = gclp_pkg::L_G;
                letter_ok  = 1'b0;
            end
        endcase
    end

    // Multiply-accumulate one digit into the value and the saturating code
    assign acc10 = (AW'(accum_reg) << 3) + (AW'(accum_reg) << 1) + AW'(dval);
    assign ic10  = (20'(num_reg.int_code) << 3) + (20'(num_reg.int_code) << 1) + 20'(dval);

    gclp_finish #(
        .FRACTION_DIGITS (FRACTION_DIGITS),
        .VALUE_WIDTH     (VALUE_WIDTH)
    ) u_finish (
        .accum      (accum_reg),
        .frac_cnt   (fc_reg),
        .flags      (num_reg),
        .letter     (letter_reg),
        .seen_mask  (mask_reg),
        .fin        (fin),
        .code_value (fin_code),
        .word_value (fin_value)
    );

    assign vidx = 2'(letter_reg - 3'd2);

    // Per-character update of the line state
    always_comb
    begin
        logic              do_between;
        logic              do_digit;
        logic              do_finish;
        logic              raise;
        gclp_pkg::status_t raise_code;

        mode_next   = mode_reg;
        letter_next = letter_reg;
        num_next    = num_reg;
        accum_next  = accum_reg;
        fc_next     = fc_reg;
        mask_next   = mask_reg;
        code_next   = code_reg;
        val_next    = val_reg;
        err_next    = err_reg;
        do_between  = 1'b0;
        do_digit    = 1'b0;
        do_finish   = 1'b0;
        raise       = 1'b0;
        raise_code  = gclp_pkg::ST_OK;

        case (mode_reg)
            M_BETWEEN:
            begin
                do_between = !eol_char;
            end
            M_AFTER_LETTER:
            begin
                if (eol_char)
                begin
                    raise      = 1'b1;
                    raise_code = gclp_pkg::ST_BAD_NUMBER;
                end
                else if (is_space)
                begin
                    mode_next = M_AFTER_LETTER;
                end
                else if ((ch_reg == gclp_pkg::CH_PLUS) || (ch_reg == gclp_pkg::CH_MINUS))
                begin
                    num_next.negative = (ch_reg == gclp_pkg::CH_MINUS);
                    mode_next         = M_NUMBER;
                end
                else if (is_digit || (ch_reg == gclp_pkg::CH_DOT))
                begin
                    mode_next = M_NUMBER;
                    do_digit  = 1'b1;
                end
                else
                begin
                    raise      = 1'b1;
                    raise_code = gclp_pkg::ST_BAD_NUMBER;
                end
            end
            M_NUMBER:
            begin
                if (!eol_char && (is_digit ||
                    ((ch_reg == gclp_pkg::CH_DOT) && !num_reg.dot_seen)))
                begin
                    do_digit = 1'b1;
                end
                else
                begin
                    do_finish = 1'b1;
                end
            end
            M_COMMENT:
            begin
                if (eol_char)
                begin
                    raise      = 1'b1;
                    raise_code = gclp_pkg::ST_OPEN_COMMENT;
                end
                else if (ch_reg == gclp_pkg::CH_RPAR)
                begin
                    mode_next = M_BETWEEN;
                end
            end
            default:
            begin
                mode_next = mode_reg;
            end
        endcase

        // Take a digit or the decimal point
        if (do_digit)
        begin
            if (is_digit)
            begin
                num_next.digit_seen = 1'b1;
                if (!num_reg.dot_seen || (fc_reg < FCW'(FRACTION_DIGITS)))
                begin
                    if (!num_reg.overflow)
                    begin
                        if (acc10 > LIM)
                        begin
                            num_next.overflow = 1'b1;
                        end
                        else
                        begin
                            accum_next = acc10[VALUE_WIDTH-1:0];
                        end
                    end
                end
                if (!num_reg.dot_seen)
                begin
                    num_next.int_code = (ic10 > 20'(gclp_pkg::CODE_SAT)) ?
                                        gclp_pkg::CODE_SAT : ic10[15:0];
                end
                else if (fc_reg < FCW'(FRACTION_DIGITS))
                begin
                    fc_next = fc_reg + FCW'(1);
                    if (dval != 4'd0)
                    begin
                        num_next.frac_nz = 1'b1;
                    end
                end
            end
            else
            begin
                num_next.dot_seen = 1'b1;
            end
        end

        // Close the number and store the word
        if (do_finish)
        begin
            if (fin.err != gclp_pkg::ST_OK)
            begin
                raise      = 1'b1;
                raise_code = fin.err;
            end
            else
            begin
                mask_next = mask_reg | fin.word_bit;
                if ((letter_reg == gclp_pkg::L_G) || (letter_reg == gclp_pkg::L_M))
                begin
                    code_next[letter_reg[0]] = fin_code;
                end
                else
                begin
                    val_next[vidx] = fin_value;
                end
                mode_next  = M_BETWEEN;
                do_between = !eol_char;
            end
        end

        // Look for the next word
        if (do_between)
        begin
            if (is_space)
            begin
                mode_next = M_BETWEEN;
            end
            else if (ch_reg == gclp_pkg::CH_SEMI)
            begin
                mode_next = M_SKIP;
            end
            else if (ch_reg == gclp_pkg::CH_LPAR)
            begin
                mode_next = M_COMMENT;
            end
            else if (letter_ok)
            begin
                letter_next = letter_dec;
                num_next    = '0;
                accum_next  = '0;
                fc_next     = '0;
                mode_next   = M_AFTER_LETTER;
            end
            else
            begin
                raise      = 1'b1;
                raise_code = gclp_pkg::ST_UNSUPPORTED;
            end
        end

        // Keep the first error, skip the rest of the line
        if (raise)
        begin
            if (err_reg == gclp_pkg::ST_OK)
            begin
                err_next = raise_code;
            end
            mode_next = M_SKIP;
        end
    end

    // Status of a finished line
    always_comb
    begin
        if (err_next != gclp_pkg::ST_OK)
        begin
            final_status = err_next;
        end
        else if (mask_next != 6'd0)
        begin
            final_status = gclp_pkg::ST_OK;
        end
        else
        begin
            final_status = gclp_pkg::ST_EMPTY;
        end
    end

    // Advance line state; clear it when the line ends
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= M_BETWEEN;
            letter_reg  <= gclp_pkg::L_G;
            num_reg     <= '0;
            accum_reg   <= '0;
            fc_reg      <= '0;
            mask_reg    <= '0;
            code_reg    <= '{default: '0};
            val_reg     <= '{default: '0};
            err_reg     <= gclp_pkg::ST_OK;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (eol_adv)
            begin
                mode_reg    <= M_BETWEEN;
                letter_reg  <= gclp_pkg::L_G;
                num_reg     <= '0;
                accum_reg   <= '0;
                fc_reg      <= '0;
                mask_reg    <= '0;
                code_reg    <= '{default: '0};
                val_reg     <= '{default: '0};
                err_reg     <= gclp_pkg::ST_OK;
            end
            else if (advance)
            begin
                mode_reg    <= mode_next;
                letter_reg  <= letter_next;
                num_reg     <= num_next;
                accum_reg   <= accum_next;
                fc_reg      <= fc_next;
                mask_reg    <= mask_next;
                code_reg    <= code_next;
                val_reg     <= val_next;
                err_reg     <= err_next;
            end

            if (eol_adv)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // Capture the result beat
    always_ff @(posedge clk)
    begin
        if (eol_adv)
        begin
            res_status_reg  <= final_status;
            res_mask_reg    <= mask_next;
            res_code_reg[0] <= code_next[0];
            res_code_reg[1] <= code_next[1];
            res_val_reg[0]  <= 32'(val_next[0]);
            res_val_reg[1]  <= 32'(val_next[1]);
            res_val_reg[2]  <= 32'(val_next[2]);
            res_val_reg[3]  <= 32'(val_next[3]);
        end
    end

    assign results.valid        = out_vld_reg;
    assign results.status       = res_status_reg;
    assign results.present_mask = res_mask_reg;
    assign results.g_code       = $signed(res_code_reg[0]);
    assign results.m_code       = $signed(res_code_reg[1]);
    assign results.x_value      = $signed(res_val_reg[0]);
    assign results.y_value      = $signed(res_val_reg[1]);
    assign results.feed_value   = $signed(res_val_reg[2]);
    assign results.s_value      = $signed(res_val_reg[3]);

    // A result beat only appears after a line end was taken
    a_result_after_eol: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_vld_reg) |-> $past(eol_adv))
        else $error("result beat without a line end");

    // Line state is clean after every line end
    a_line_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        eol_adv |=> (mode_reg == M_BETWEEN) && (mask_reg == 6'd0) &&
                    (err_reg == gclp_pkg::ST_OK))
        else $error("line state not cleared after line end");

    // Empty status carries no words
    a_empty_no_words: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && (res_status_reg == gclp_pkg::ST_EMPTY) |-> (res_mask_reg == 6'd0))
        else $error("empty line reports words");

    // OK status carries at least one word
    a_ok_has_words: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && (res_status_reg == gclp_pkg::ST_OK) |-> (res_mask_reg != 6'd0))
        else $error("ok line reports no words");

    // A missing X word reads as zero
    a_absent_x_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && !res_mask_reg[2] |-> (res_val_reg[0] == 32'd0))
        else $error("absent X word has a value");

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// G-code line parser core testbench
// Sends G-code lines to the core one character beat at a time. A directed
// table comes first, then random lines that are mostly well formed and partly
// noise. A line predictor works out the result of each line. Every result
// beat is checked field by field against the oldest pending line. The sender
// and the receiver idle at random in the first two of three pacing phases.
// ----------------------------------------------------------------------------
module tb;

    localparam int              FRAC_DIGITS = gclp_pkg::FRACTION_DIGITS_DEF;
    localparam longint unsigned MAG_LIMIT   = 64'd1 << (gclp_pkg::VALUE_WIDTH_DEF - 1);
    localparam longint unsigned FRAC_SCALE  = 10 ** gclp_pkg::FRACTION_DIGITS_DEF;
    localparam int              CYCLE_LIMIT = 200_000;
    localparam int              SETTLE      = 20;
    localparam logic [7:0]      CH_TAB      = 8'h09;
    localparam logic [7:0]      CH_CR       = 8'h0D;

    // Parser states of the line predictor
    typedef enum logic [2:0] {
        PM_BETWEEN,
        PM_AFTER_LETTER,
        PM_NUMBER,
        PM_COMMENT,
        PM_SKIP
    } parse_mode_t;

    typedef struct packed {
        gclp_pkg::status_t  status;
        logic        [5:0]  present_mask;
        logic signed [15:0] g_code;
        logic signed [15:0] m_code;
        logic signed [31:0] x_value;
        logic signed [31:0] y_value;
        logic signed [31:0] feed_value;
        logic signed [31:0] s_value;
    } line_result_t;

    typedef struct {
        string        text;
        bit           typed;
        line_result_t exp_line;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;

    gclp_char_if   chars ();
    gclp_result_if results ();

    gcode_line_parser_core DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .chars   (chars),
        .results (results)
    );

    // Line predictor state
    parse_mode_t       pmode;
    gclp_pkg::letter_t cur_letter;
    bit                neg;
    bit                dig_seen;
    bit                dot_seen;
    bit                acc_ovf;
    longint unsigned   acc;
    int unsigned       frac_cnt;
    logic [5:0]        word_mask;
    logic [15:0]       code_val [2];
    logic [31:0]       value_val [4];
    gclp_pkg::status_t line_err;

    // Bench bookkeeping
    line_result_t    pending_lines [$];
    stim_row_t       directed_rows [$];
    logic [7:0]      line_bytes [$];
    int              src_idle_pct;
    int              snk_stall_pct;
    int              error_count;
    int              chars_sent;
    int              lines_sent;
    int              results_seen;
    int              status_hits [8];
    int              cycle_count;

    // Clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
    end

    function automatic bit is_blank(input logic [7:0] c);
        return c == gclp_pkg::CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic bit is_digit(input logic [7:0] c);
        return c >= gclp_pkg::CH_ZERO && c <= gclp_pkg::CH_NINE;
    endfunction

    function automatic void clear_line();
        pmode      = PM_BETWEEN;
        cur_letter = gclp_pkg::L_G;
        neg        = 1'b0;
        dig_seen   = 1'b0;
        dot_seen   = 1'b0;
        acc_ovf    = 1'b0;
        acc        = 0;
        frac_cnt   = 0;
        word_mask  = '0;
        code_val   = '{default: '0};
        value_val  = '{default: '0};
        line_err   = gclp_pkg::ST_OK;
    endfunction

    // Keep the first error, skip the rest of the line
    function automatic void flag_error(input gclp_pkg::status_t e);
        if (line_err == gclp_pkg::ST_OK)
            line_err = e;
        pmode = PM_SKIP;
    endfunction

    function automatic void add_digit(input int unsigned d);
        if (acc_ovf)
            return;
        if (acc > (MAG_LIMIT - d) / 10)
        begin
            acc_ovf = 1'b1;
            return;
        end
        acc = acc * 10 + d;
    endfunction

    function automatic void number_char(input logic [7:0] c);
        if (is_digit(c))
        begin
            dig_seen = 1'b1;
            if (!dot_seen)
                add_digit(c - gclp_pkg::CH_ZERO);
            else if (frac_cnt < FRAC_DIGITS)
            begin
                add_digit(c - gclp_pkg::CH_ZERO);
                frac_cnt++;
            end
        end
        else
            dot_seen = 1'b1;
    endfunction

    // Scale the number, range check it and store the word
    function automatic void close_number();
        longint unsigned ip;
        longint unsigned fp;
        int unsigned     k;
        if (!dig_seen)
        begin
            flag_error(gclp_pkg::ST_BAD_NUMBER);
            return;
        end
        for (k = frac_cnt; k < FRAC_DIGITS; k++)
            add_digit(0);
        if (acc_ovf || (!neg && acc > MAG_LIMIT - 1))
        begin
            flag_error(gclp_pkg::ST_BAD_NUMBER);
            return;
        end
        if (cur_letter == gclp_pkg::L_G || cur_letter == gclp_pkg::L_M)
        begin
            ip = acc / FRAC_SCALE;
            fp = acc % FRAC_SCALE;
            if (fp != 0)
            begin
                flag_error(gclp_pkg::ST_NONINTEGER);
                return;
            end
            if (ip > (neg ? gclp_pkg::CODE_NEG_MAX : gclp_pkg::CODE_POS_MAX))
            begin
                flag_error(gclp_pkg::ST_BAD_NUMBER);
                return;
            end
            if (word_mask[cur_letter])
            begin
                flag_error(gclp_pkg::ST_DUPLICATE);
                return;
            end
            word_mask[cur_letter] = 1'b1;
            code_val[cur_letter]  = neg ? 16'(0 - ip) : 16'(ip);
        end
        else
        begin
            if (word_mask[cur_letter])
            begin
                flag_error(gclp_pkg::ST_DUPLICATE);
                return;
            end
            word_mask[cur_letter]                  = 1'b1;
            value_val[cur_letter - gclp_pkg::L_X]  = neg ? 32'(0 - acc) : 32'(acc);
        end
        pmode = PM_BETWEEN;
    endfunction

    // Character where a word may start
    function automatic void word_start(input logic [7:0] c);
        logic [7:0] up;
        up = (c >= "a" && c <= "z") ? c - ("a" - "A") : c;
        if (is_blank(c))
            return;
        if (c == gclp_pkg::CH_SEMI)
        begin
            pmode = PM_SKIP;
            return;
        end
        if (c == gclp_pkg::CH_LPAR)
        begin
            pmode = PM_COMMENT;
            return;
        end
        case (up)
            "G": cur_letter = gclp_pkg::L_G;
            "M": cur_letter = gclp_pkg::L_M;
            "X": cur_letter = gclp_pkg::L_X;
            "Y": cur_letter = gclp_pkg::L_Y;
            "F": cur_letter = gclp_pkg::L_F;
            "S": cur_letter = gclp_pkg::L_S;
            default:
            begin
                flag_error(gclp_pkg::ST_UNSUPPORTED);
                return;
            end
        endcase
        neg      = 1'b0;
        acc      = 0;
        frac_cnt = 0;
        dig_seen = 1'b0;
        dot_seen = 1'b0;
        acc_ovf  = 1'b0;
        pmode    = PM_AFTER_LETTER;
    endfunction

    // Advance the predictor by one nonzero character
    function automatic void take_char(input logic [7:0] c);
        case (pmode)
            PM_BETWEEN:
                word_start(c);
            PM_AFTER_LETTER:
                if (!is_blank(c))
                begin
                    if (c == gclp_pkg::CH_PLUS || c == gclp_pkg::CH_MINUS)
                    begin
                        neg   = (c == gclp_pkg::CH_MINUS);
                        pmode = PM_NUMBER;
                    end
                    else if (is_digit(c) || c == gclp_pkg::CH_DOT)
                    begin
                        pmode = PM_NUMBER;
                        number_char(c);
                    end
                    else
                        flag_error(gclp_pkg::ST_BAD_NUMBER);
                end
            PM_NUMBER:
                if (is_digit(c) || (c == gclp_pkg::CH_DOT && !dot_seen))
                    number_char(c);
                else
                begin
                    close_number();
                    if (pmode == PM_BETWEEN)
                        word_start(c);
                end
            PM_COMMENT:
                if (c == gclp_pkg::CH_RPAR)
                    pmode = PM_BETWEEN;
            default:
                ;
        endcase
    endfunction

    // End of line: build the result and clear the line state
    function automatic line_result_t close_line();
        line_result_t r;
        if (pmode == PM_NUMBER)
            close_number();
        else if (pmode == PM_AFTER_LETTER)
            flag_error(gclp_pkg::ST_BAD_NUMBER);
        else if (pmode == PM_COMMENT)
            flag_error(gclp_pkg::ST_OPEN_COMMENT);
        if (line_err != gclp_pkg::ST_OK)
            r.status = line_err;
        else if (word_mask != 0)
            r.status = gclp_pkg::ST_OK;
        else
            r.status = gclp_pkg::ST_EMPTY;
        r.present_mask = word_mask;
        r.g_code       = code_val[gclp_pkg::L_G];
        r.m_code       = code_val[gclp_pkg::L_M];
        r.x_value      = value_val[gclp_pkg::L_X - gclp_pkg::L_X];
        r.y_value      = value_val[gclp_pkg::L_Y - gclp_pkg::L_X];
        r.feed_value   = value_val[gclp_pkg::L_F - gclp_pkg::L_X];
        r.s_value      = value_val[gclp_pkg::L_S - gclp_pkg::L_X];
        clear_line();
        return r;
    endfunction

    function automatic line_result_t want(input gclp_pkg::status_t st,
                                          input logic [5:0] mask,
                                          input int g, input int m, input int x,
                                          input int y, input int f, input int s);
        line_result_t r;
        r.status       = st;
        r.present_mask = mask;
        r.g_code       = 16'(g);
        r.m_code       = 16'(m);
        r.x_value      = x;
        r.y_value      = y;
        r.feed_value   = f;
        r.s_value      = s;
        return r;
    endfunction

    task automatic add_row(input string text, input bit typed, input line_result_t e);
        stim_row_t row;
        row.text     = text;
        row.typed    = typed;
        row.exp_line = e;
        directed_rows.push_back(row);
    endtask

    task automatic set_pace(input int src, input int snk);
        src_idle_pct  = src;
        snk_stall_pct = snk;
    endtask

    // Drive one character beat and hold it until accepted
    task automatic send_byte(input logic [7:0] b);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            chars.valid <= 1'b0;
            @(negedge clk);
        end
        chars.valid     <= 1'b1;
        chars.char_byte <= b;
        @(posedge clk);
        while (!chars.ready)
            @(posedge clk);
        chars_sent++;
    endtask

    // Send line_bytes plus the terminating zero and queue the line's result
    task automatic send_line(input bit typed, input line_result_t e);
        line_result_t r;
        foreach (line_bytes[i])
        begin
            send_byte(line_bytes[i]);
            take_char(line_bytes[i]);
        end
        send_byte(gclp_pkg::CH_NUL);
        r = close_line();
        pending_lines.push_back(typed ? e : r);
        lines_sent++;
    endtask

    // Drop valid and wait until every pending line has its result
    task automatic drain_results();
        @(negedge clk);
        chars.valid <= 1'b0;
        while (pending_lines.size() != 0)
            @(posedge clk);
    endtask

    task automatic push_text(input string t);
        for (int i = 0; i < t.len(); i++)
            line_bytes.push_back(t[i]);
    endtask

    task automatic push_blanks();
        int n;
        n = ($urandom_range(2) == 0) ? $urandom_range(1, 2) : 0;
        repeat (n)
            line_bytes.push_back(($urandom_range(2) == 0) ? 8'(CH_TAB + $urandom_range(4))
                                                          : gclp_pkg::CH_SPACE);
    endtask

    task automatic push_digits(input int n);
        repeat (n)
            line_bytes.push_back(8'(gclp_pkg::CH_ZERO + $urandom_range(9)));
    endtask

    task automatic push_sign();
        case ($urandom_range(5))
            0: line_bytes.push_back(gclp_pkg::CH_MINUS);
            1: line_bytes.push_back(gclp_pkg::CH_PLUS);
            default: ;
        endcase
    endtask

    task automatic push_comment(input bit closed);
        logic [7:0] c;
        line_bytes.push_back(gclp_pkg::CH_LPAR);
        repeat ($urandom_range(6))
        begin
            do
                c = 8'($urandom_range(1, 255));
            while (c == gclp_pkg::CH_RPAR);
            line_bytes.push_back(c);
        end
        if (closed)
            line_bytes.push_back(gclp_pkg::CH_RPAR);
    endtask

    // One word: letter in either case, optional blanks, a number
    task automatic push_word(input int k);
        string      word_letters;
        logic [7:0] c;
        int         pick;
        int         n_int;
        word_letters = "GMXYFS";
        c = word_letters[k];
        if ($urandom_range(1))
            c = c + ("a" - "A");
        line_bytes.push_back(c);
        push_blanks();
        push_sign();
        if (k < 2)
        begin
            pick = $urandom_range(9);
            if (pick == 0)
                push_text($sformatf("%0d", $urandom_range(40000)));
            else if (pick == 1)
                push_text($sformatf("%0d", $urandom_range(32766, 32769)));
            else
                push_text($sformatf("%0d", $urandom_range(99)));
            case ($urandom_range(7))
                0: push_text(".0");
                1: push_text(".5");
                2: push_text(".0009");
                3: push_text(".");
                default: ;
            endcase
        end
        else
        begin
            n_int = ($urandom_range(9) == 0) ? $urandom_range(7, 11) : $urandom_range(0, 5);
            push_digits(n_int);
            if (n_int == 0 || $urandom_range(1))
            begin
                line_bytes.push_back(gclp_pkg::CH_DOT);
                push_digits($urandom_range(n_int == 0 ? 1 : 0, 5));
            end
        end
    endtask

    // Random line: mostly well-formed words, some noise and broken lines
    task automatic make_random_line();
        int order [6];
        int j;
        int t;
        int kind;
        line_bytes.delete();
        kind = $urandom_range(99);
        if (kind < 8)
        begin
            repeat ($urandom_range(1, 10))
                line_bytes.push_back(8'($urandom_range(1, 255)));
            return;
        end
        foreach (order[k])
            order[k] = k;
        for (int k = 5; k > 0; k--)
        begin
            j        = $urandom_range(k);
            t        = order[k];
            order[k] = order[j];
            order[j] = t;
        end
        push_blanks();
        foreach (order[k])
        begin
            if ($urandom_range(1))
            begin
                push_word(order[k]);
                push_blanks();
                if ($urandom_range(11) == 0)
                    push_comment(1'b1);
            end
        end
        if ($urandom_range(14) == 0)
            push_word($urandom_range(5));
        if (kind < 13)
            line_bytes.insert($urandom_range(line_bytes.size()), 8'($urandom_range(1, 255)));
        else if (kind < 16)
            push_text("f");
        else if (kind < 19)
            push_comment(1'b0);
        else if (kind < 30)
        begin
            line_bytes.push_back(gclp_pkg::CH_SEMI);
            repeat ($urandom_range(5))
                line_bytes.push_back(8'($urandom_range(1, 255)));
        end
    endtask

    task automatic match_field(input string name, input longint exp_v, input longint got_v);
        if (exp_v != got_v)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, got_v);
            error_count++;
        end
    endtask

    // Check each result beat against the oldest pending line
    always @(posedge clk)
    begin
        line_result_t e;
        if (rst_n === 1'b1 && results.valid === 1'b1 && results.ready === 1'b1)
        begin
            results_seen++;
            status_hits[results.status]++;
            if (pending_lines.size() == 0)
            begin
                $error("result beat with no line pending");
                error_count++;
            end
            else
            begin
                e = pending_lines.pop_front();
                match_field("status", e.status, results.status);
                match_field("present_mask", e.present_mask, results.present_mask);
                match_field("g_code", $signed(e.g_code), results.g_code);
                match_field("m_code", $signed(e.m_code), results.m_code);
                match_field("x_value", $signed(e.x_value), results.x_value);
                match_field("y_value", $signed(e.y_value), results.y_value);
                match_field("feed_value", $signed(e.feed_value), results.feed_value);
                match_field("s_value", $signed(e.s_value), results.s_value);
            end
        end
    end

    // Result ready, stalled at random
    initial
    begin
        results.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            results.ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // Stimulus
    initial
    begin
        int lines_random;
        chars.valid     = 1'b0;
        chars.char_byte = gclp_pkg::CH_NUL;
        rst_n           = 1'b0;
        error_count     = 0;
        chars_sent      = 0;
        lines_sent      = 0;
        results_seen    = 0;
        cycle_count     = 0;
        lines_random    = 0;
        status_hits     = '{default: 0};
        clear_line();
        set_pace(11, 63);

        // Directed lines: extremes, every status, blanks, comments, case
        add_row("", 1, want(gclp_pkg::ST_EMPTY, 6'b000000, 0, 0, 0, 0, 0, 0));
        add_row(" \t(note) ;G1", 1, want(gclp_pkg::ST_EMPTY, 6'b000000, 0, 0, 0, 0, 0, 0));
        add_row("G0", 0, '0);
        add_row("g32767 m-32768", 1,
                want(gclp_pkg::ST_OK, 6'b000011, 32767, -32768, 0, 0, 0, 0));
        add_row("G32768", 1, want(gclp_pkg::ST_BAD_NUMBER, 6'b000000, 0, 0, 0, 0, 0, 0));
        add_row("M-32769", 1, want(gclp_pkg::ST_BAD_NUMBER, 6'b000000, 0, 0, 0, 0, 0, 0));
        add_row("X2147483.647", 1,
                want(gclp_pkg::ST_OK, 6'b000100, 0, 0, 32'sh7FFFFFFF, 0, 0, 0));
        add_row("y-2147483.648", 1,
                want(gclp_pkg::ST_OK, 6'b001000, 0, 0, 0, 32'sh80000000, 0, 0));
        add_row("F2147483.648", 1,
                want(gclp_pkg::ST_BAD_NUMBER, 6'b000000, 0, 0, 0, 0, 0, 0));
        add_row("S+.0009", 0, '0);
        add_row("G1.0009X-1.5", 0, '0);
        add_row("G1.5", 1, want(gclp_pkg::ST_NONINTEGER, 6'b000000, 0, 0, 0, 0, 0, 0));
        add_row("G1 M2 g3", 1, want(gclp_pkg::ST_DUPLICATE, 6'b000011, 1, 2, 0, 0, 0, 0));
        add_row("X1 Q2", 1, want(gclp_pkg::ST_UNSUPPORTED, 6'b000100, 0, 0, 1000, 0, 0, 0));
        add_row("X", 1, want(gclp_pkg::ST_BAD_NUMBER, 6'b000000, 0, 0, 0, 0, 0, 0));
        add_row("X -", 1, want(gclp_pkg::ST_BAD_NUMBER, 6'b000000, 0, 0, 0, 0, 0, 0));
        add_row("X.", 1, want(gclp_pkg::ST_BAD_NUMBER, 6'b000000, 0, 0, 0, 0, 0, 0));
        add_row("Y*", 1, want(gclp_pkg::ST_BAD_NUMBER, 6'b000000, 0, 0, 0, 0, 0, 0));
        add_row("(open", 1, want(gclp_pkg::ST_OPEN_COMMENT, 6'b000000, 0, 0, 0, 0, 0, 0));
        add_row("\377G1", 1, want(gclp_pkg::ST_UNSUPPORTED, 6'b000000, 0, 0, 0, 0, 0, 0));
        add_row("G1X5Y-0.25F1200S.", 0, '0);
        add_row("x\t+12.3456\r\nf 0", 0, '0);
        add_row("X1.2.3", 0, '0);
        add_row("X99999999", 0, '0);
        add_row("M3 S1000 ;tail X9", 0, '0);

        // Reset
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
        begin
            line_bytes.delete();
            push_text(directed_rows[i].text);
            send_line(directed_rows[i].typed, directed_rows[i].exp_line);
        end

        // Random lines in three pacing phases, draining at each switch
        while (chars_sent < 400 || lines_random < 9)
        begin
            if (lines_random == 3)
            begin
                drain_results();
                set_pace(63, 11);
            end
            else if (lines_random == 6)
            begin
                drain_results();
                set_pace(0, 0);
            end
            make_random_line();
            send_line(1'b0, '0);
            lines_random++;
        end

        drain_results();
        repeat (SETTLE) @(posedge clk);

        $display("Covered %0d lines in %0d character beats, %0d results checked.",
                 lines_sent, chars_sent, results_seen);
        $display("Statuses: ok %0d, empty %0d, bad %0d, dup %0d, unsup %0d, nonint %0d, open %0d",
                 status_hits[gclp_pkg::ST_OK], status_hits[gclp_pkg::ST_EMPTY],
                 status_hits[gclp_pkg::ST_BAD_NUMBER], status_hits[gclp_pkg::ST_DUPLICATE],
                 status_hits[gclp_pkg::ST_UNSUPPORTED], status_hits[gclp_pkg::ST_NONINTEGER],
                 status_hits[gclp_pkg::ST_OPEN_COMMENT]);
        if (error_count == 0 && pending_lines.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
